@@ hdl/exception_dispatch_perf_monitor_defines.svh @@
// Assertion macros for the exception dispatch and performance monitor block.
`ifndef EXCEPTION_DISPATCH_PERF_MONITOR_DEFINES_SVH
`define EXCEPTION_DISPATCH_PERF_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition in the same cycle as its trigger.
`define EDPM_ASSERT_NOW(name, clock, reset, trig, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define EDPM_ASSERT_NEXT(name, clock, reset, trig, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error(msg);

`else

`define EDPM_ASSERT_NOW(name, clock, reset, trig, cond, msg)
`define EDPM_ASSERT_NEXT(name, clock, reset, trig, cond, msg)

`endif

`endif

@@ hdl/edpm_pkg.sv @@
// Package: types, codes and constants of the exception dispatch and performance monitor.
`timescale 1ns / 1ps
`default_nettype none

package edpm_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_RAISE     = 2'd0,
    KIND_COUNT     = 2'd1,
    KIND_CHECK_ALL = 2'd2,
    KIND_CHECK_EXT = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CFG_PMC1_SELECT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PMC2_SELECT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PMC3_SELECT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PMC4_SELECT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PMC1_INT_ENABLE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PMCN_INT_ENABLE = 3'd5;

  // Event select codes
  localparam logic [6:0] SEL_CYCLES     = 7'd1;
  localparam logic [6:0] SEL_LOAD_STORE = 7'd11;
  localparam logic [6:0] SEL_FPU        = 7'd11;

  // Pending bit positions
  localparam int P_ISI   = 0;
  localparam int P_PROG  = 1;
  localparam int P_SC    = 2;
  localparam int P_FPU   = 3;
  localparam int P_MCHK  = 4;
  localparam int P_DSI   = 5;
  localparam int P_ALIGN = 6;
  localparam int P_EXT   = 7;
  localparam int P_PERF  = 8;
  localparam int P_DEC   = 9;
  localparam int PendW   = 10;

  // Exception vectors
  localparam logic [11:0] VEC_DSI   = 12'h300;
  localparam logic [11:0] VEC_ISI   = 12'h400;
  localparam logic [11:0] VEC_EXT   = 12'h500;
  localparam logic [11:0] VEC_ALIGN = 12'h600;
  localparam logic [11:0] VEC_PROG  = 12'h700;
  localparam logic [11:0] VEC_FPU   = 12'h800;
  localparam logic [11:0] VEC_DEC   = 12'h900;
  localparam logic [11:0] VEC_SC    = 12'hC00;
  localparam logic [11:0] VEC_PERF  = 12'hF00;

  // MSR / SRR1 masks and bits
  localparam logic [31:0] SRR1_KEEP  = 32'h87C0FFFF;
  localparam logic [31:0] MSR_CLEAR  = 32'h0004EF36;
  localparam logic [31:0] ISI_REASON = 32'h40000000;
  localparam int MSR_LE  = 0;
  localparam int MSR_EE  = 15;
  localparam int MSR_ILE = 16;
  localparam int TopBit  = 31;

  typedef logic [3:0][31:0] counters_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  raise_mask;
    logic [31:0] cycle_count;
    logic [31:0] load_store_count;
    logic [31:0] fp_count;
    logic [31:0] cur_pc;
    logic [31:0] next_pc;
    logic [31:0] msr_in;
    logic [31:0] srr1_prior;
  } item_t;

  typedef struct packed {
    logic [6:0] pmc1_select;
    logic [5:0] pmc2_select;
    logic [4:0] pmc3_select;
    logic [4:0] pmc4_select;
    logic       pmc1_int_enable;
    logic       pmcn_int_enable;
  } cfg_t;

  typedef struct packed {
    logic        taken;
    logic [11:0] vector;
    logic [31:0] srr0_out;
    logic [31:0] srr1_out;
    logic [31:0] msr_out;
    logic        unknown_external;
  } disp_t;

endpackage

`default_nettype wire

@@ hdl/edpm_core.sv @@
// Combinational step: pending update, counter adds and exception dispatch for one item.
`timescale 1ns / 1ps
`default_nettype none

module edpm_core
  import edpm_pkg::*;
(
  input  item_t            item,
  input  cfg_t             cfg,
  input  logic [PendW-1:0] pending,
  input  counters_t        counters,
  output logic [PendW-1:0] pending_next,
  output counters_t        counters_next,
  output disp_t            res
);

  logic             ext_chk;
  logic             take;
  logic [PendW-1:0] pick;
  logic [11:0]      vec;
  logic             use_npc;
  logic [31:0]      reason;
  logic [31:0]      msr_le;
  logic [31:0]      ctop;

  assign msr_le = {item.msr_in[31:1], item.msr_in[MSR_ILE]};

  always_comb begin
    pending_next = pending;
    counters_next = counters;
    ext_chk = 1'b0;
    take = 1'b0;
    pick = '0;
    vec = '0;
    use_npc = 1'b0;
    reason = '0;
    res.taken = 1'b0;
    res.vector = '0;
    res.srr0_out = '0;
    res.srr1_out = '0;
    res.msr_out = item.msr_in;
    res.unknown_external = 1'b0;
    ctop = '0;

    unique case (item.kind)
      KIND_RAISE: begin
        pending_next = pending | item.raise_mask;
      end
      KIND_COUNT: begin
        if (cfg.pmc1_select == SEL_CYCLES) begin
          counters_next[0] = counters[0] + item.cycle_count;
        end
        if (cfg.pmc2_select == SEL_CYCLES[5:0]) begin
          counters_next[1] = counters[1] + item.cycle_count;
        end else if (cfg.pmc2_select == SEL_LOAD_STORE[5:0]) begin
          counters_next[1] = counters[1] + item.load_store_count;
        end
        if (cfg.pmc3_select == SEL_CYCLES[4:0]) begin
          counters_next[2] = counters[2] + item.cycle_count;
        end else if (cfg.pmc3_select == SEL_FPU[4:0]) begin
          counters_next[2] = counters[2] + item.fp_count;
        end
        if (cfg.pmc4_select == SEL_CYCLES[4:0]) begin
          counters_next[3] = counters[3] + item.cycle_count;
        end
        ctop = counters_next[1] | counters_next[2] | counters_next[3];
        if ((cfg.pmc1_int_enable && counters_next[0][TopBit]) ||
            (cfg.pmcn_int_enable && ctop[TopBit])) begin
          pending_next[P_PERF] = 1'b1;
        end
      end
      KIND_CHECK_ALL: begin
        priority if (pending[P_ISI]) begin
          take = 1'b1; pick[P_ISI] = 1'b1; vec = VEC_ISI;
          use_npc = 1'b1; reason = ISI_REASON;
        end else if (pending[P_PROG]) begin
          take = 1'b1; pick[P_PROG] = 1'b1; vec = VEC_PROG; reason = item.srr1_prior;
        end else if (pending[P_SC]) begin
          take = 1'b1; pick[P_SC] = 1'b1; vec = VEC_SC; use_npc = 1'b1;
        end else if (pending[P_FPU]) begin
          take = 1'b1; pick[P_FPU] = 1'b1; vec = VEC_FPU;
        end else if (pending[P_MCHK]) begin
          // Drop memcheck and dsi together; nothing is dispatched
          pending_next[P_MCHK] = 1'b0;
          pending_next[P_DSI] = 1'b0;
        end else if (pending[P_DSI]) begin
          take = 1'b1; pick[P_DSI] = 1'b1; vec = VEC_DSI;
        end else if (pending[P_ALIGN]) begin
          take = 1'b1; pick[P_ALIGN] = 1'b1; vec = VEC_ALIGN;
        end else begin
          ext_chk = 1'b1;
        end
      end
      KIND_CHECK_EXT: begin
        ext_chk = 1'b1;
      end
      default: begin
      end
    endcase

    if (ext_chk && (pending != '0) && item.msr_in[MSR_EE]) begin
      priority if (pending[P_EXT]) begin
        take = 1'b1; pick[P_EXT] = 1'b1; vec = VEC_EXT; use_npc = 1'b1;
      end else if (pending[P_PERF]) begin
        take = 1'b1; pick[P_PERF] = 1'b1; vec = VEC_PERF; use_npc = 1'b1;
      end else if (pending[P_DEC]) begin
        take = 1'b1; pick[P_DEC] = 1'b1; vec = VEC_DEC; use_npc = 1'b1;
      end else begin
        res.unknown_external = 1'b1;
      end
    end

    if (take) begin
      res.taken = 1'b1;
      res.vector = vec;
      res.srr0_out = use_npc ? item.next_pc : item.cur_pc;
      res.srr1_out = (item.msr_in & SRR1_KEEP) | reason;
      res.msr_out = msr_le & ~MSR_CLEAR;
      pending_next = pending & ~pick;
    end
  end

endmodule

`default_nettype wire

@@ hdl/exception_dispatch_perf_monitor.sv @@
// Top level: stream ports, configuration registers, state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Exception dispatch and performance monitor. Each item on the slave stream
// (kind in s_tuser) raises pending exceptions, adds event counts to the four
// 32-bit performance counters, or dispatches the highest-priority pending
// exception, giving vector, SRR0, SRR1 and new MSR. Every item yields exactly
// one result on the master stream, carrying the pending vector and counters
// as they stand after that item. Throughput is one item per clock while
// m_tready is high: an item is held in an input register, and in the cycle
// it moves on, one shallow combinational step reads and rewrites the pending
// vector and counters and loads the output register. With the output register
// free, an item passes from the input register into the output register,
// which raises m_tvalid. While a result waits, the input register still
// takes one more item; with both registers full, s_tready drops until
// m_tready returns. Write configuration only while the block is idle; the
// write enable takes effect at the clock edge, with no read-back.

`include "exception_dispatch_perf_monitor_defines.svh"

module exception_dispatch_perf_monitor
  import edpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Slave stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata, low bit up: raise_mask[9:0], cycle_count[41:10],
  // load_store_count[73:42], fp_count[105:74], cur_pc[137:106],
  // next_pc[169:138], msr_in[201:170], srr1_prior[233:202], zero pad
  input  logic [239:0]        s_tdata,
  input  logic [1:0]          s_tuser,   // kind
  // Master stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata, low bit up: taken[0], vector[12:1], srr0_out[44:13],
  // srr1_out[76:45], msr_out[108:77], pending_out[118:109],
  // unknown_external[119], counter1[151:120], counter2[183:152],
  // counter3[215:184], counter4[247:216]
  output logic [247:0]        m_tdata,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Input stage
  logic  in_valid;
  item_t in_item;
  logic  advance;

  // Architectural state and configuration
  cfg_t             cfg;
  logic [PendW-1:0] pending;
  counters_t        counters;

  // Step results
  logic [PendW-1:0] pending_next;
  counters_t        counters_next;
  disp_t            res;

  // Output register
  logic             out_valid;
  disp_t            out_disp;
  logic [PendW-1:0] out_pending;
  counters_t        out_counters;

  // Move the held item through the step whenever the output register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold the accepted item's fields
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind             <= kind_t'(s_tuser);
      in_item.raise_mask       <= s_tdata[9:0];
      in_item.cycle_count      <= s_tdata[41:10];
      in_item.load_store_count <= s_tdata[73:42];
      in_item.fp_count         <= s_tdata[105:74];
      in_item.cur_pc           <= s_tdata[137:106];
      in_item.next_pc          <= s_tdata[169:138];
      in_item.msr_in           <= s_tdata[201:170];
      in_item.srr1_prior       <= s_tdata[233:202];
    end
  end

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PMC1_SELECT:     cfg.pmc1_select     <= cfg_data[6:0];
        CFG_PMC2_SELECT:     cfg.pmc2_select     <= cfg_data[5:0];
        CFG_PMC3_SELECT:     cfg.pmc3_select     <= cfg_data[4:0];
        CFG_PMC4_SELECT:     cfg.pmc4_select     <= cfg_data[4:0];
        CFG_PMC1_INT_ENABLE: cfg.pmc1_int_enable <= cfg_data[0];
        CFG_PMCN_INT_ENABLE: cfg.pmcn_int_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  edpm_core u_core (
    .item          (in_item),
    .cfg           (cfg),
    .pending       (pending),
    .counters      (counters),
    .pending_next  (pending_next),
    .counters_next (counters_next),
    .res           (res)
  );

  // Pending vector and counters advance once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      counters <= '0;
    end else if (advance) begin
      pending  <= pending_next;
      counters <= counters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result together with the state it leaves behind
  always_ff @(posedge clk) begin
    if (advance) begin
      out_disp     <= res;
      out_pending  <= pending_next;
      out_counters <= counters_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_counters[3], out_counters[2], out_counters[1], out_counters[0],
                     out_disp.unknown_external, out_pending, out_disp.msr_out,
                     out_disp.srr1_out, out_disp.srr0_out, out_disp.vector,
                     out_disp.taken};

  // A dispatched exception always has a vector and never flags an unknown source
  `EDPM_ASSERT_NOW(a_taken_vec, clk, rst, advance && res.taken, (res.vector != '0) && !res.unknown_external, "taken exception without vector")
  // Nothing taken leaves the MSR as it came in
  `EDPM_ASSERT_NOW(a_notaken_msr, clk, rst, advance && !res.taken, res.msr_out == in_item.msr_in, "msr changed without dispatch")
  // Raised bits are pending right after a raise item
  `EDPM_ASSERT_NEXT(a_raise_sets, clk, rst, advance && (in_item.kind == KIND_RAISE), (pending & $past(in_item.raise_mask)) == $past(in_item.raise_mask), "raised bits not pending")
  // Only counter items move the counters
  `EDPM_ASSERT_NEXT(a_counters_hold, clk, rst, advance && (in_item.kind != KIND_COUNT), counters == $past(counters), "counters changed on non-counter item")

endmodule

`default_nettype wire

@@ test/edpm_checker.sv @@
// Checker: predicts every result of the exception dispatch and performance monitor and compares.
`timescale 1ns / 1ps
`default_nettype none

module edpm_checker
  import edpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [239:0]        s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [247:0]        m_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_seen,
  output int                  dispatched
);

  // Laid out so that the struct maps straight onto m_tdata (taken in bit 0).
  typedef struct packed {
    logic [31:0] counter4;
    logic [31:0] counter3;
    logic [31:0] counter2;
    logic [31:0] counter1;
    logic        unknown_external;
    logic [9:0]  pending_out;
    logic [31:0] msr_out;
    logic [31:0] srr1_out;
    logic [31:0] srr0_out;
    logic [11:0] vector;
    logic        taken;
  } outcome_t;

  logic [PendW-1:0] pend_vec;
  counters_t        pmc;
  logic [6:0]       sel1;
  logic [5:0]       sel2;
  logic [4:0]       sel3;
  logic [4:0]       sel4;
  logic             int_en1;
  logic             int_enn;

  outcome_t outcome_queue[$];
  outcome_t want;
  outcome_t got;
  item_t    seen;

  function automatic outcome_t take(input outcome_t r, input int pos,
                                    input logic [11:0] vec, input logic [31:0] save,
                                    input logic [31:0] reason, input logic [31:0] msr);
    logic [31:0] m;
    m = msr;
    m[MSR_LE] = msr[MSR_ILE];
    r.taken = 1'b1;
    r.vector = vec;
    r.srr0_out = save;
    r.srr1_out = (msr & SRR1_KEEP) | reason;
    r.msr_out = m & ~MSR_CLEAR;
    pend_vec[pos] = 1'b0;
    return r;
  endfunction

  function automatic outcome_t external_check(input outcome_t r, input logic [31:0] npc,
                                              input logic [31:0] msr);
    outcome_t o;
    o = r;
    if (pend_vec != '0 && msr[MSR_EE]) begin
      if (pend_vec[P_EXT])
        o = take(r, P_EXT, VEC_EXT, npc, '0, msr);
      else if (pend_vec[P_PERF])
        o = take(r, P_PERF, VEC_PERF, npc, '0, msr);
      else if (pend_vec[P_DEC])
        o = take(r, P_DEC, VEC_DEC, npc, '0, msr);
      else
        o.unknown_external = 1'b1;
    end
    return o;
  endfunction

  // Advance the predicted state by one item and return the result it yields.
  function automatic outcome_t next_outcome(input item_t it);
    outcome_t r;
    r = '0;
    r.msr_out = it.msr_in;
    case (it.kind)
      KIND_RAISE: pend_vec = pend_vec | it.raise_mask;
      KIND_COUNT: begin
        if (sel1 == SEL_CYCLES) pmc[0] = pmc[0] + it.cycle_count;
        if (sel2 == SEL_CYCLES) pmc[1] = pmc[1] + it.cycle_count;
        else if (sel2 == SEL_LOAD_STORE) pmc[1] = pmc[1] + it.load_store_count;
        if (sel3 == SEL_CYCLES) pmc[2] = pmc[2] + it.cycle_count;
        else if (sel3 == SEL_FPU) pmc[2] = pmc[2] + it.fp_count;
        if (sel4 == SEL_CYCLES) pmc[3] = pmc[3] + it.cycle_count;
        if ((int_en1 && pmc[0][TopBit]) ||
            (int_enn && (pmc[1][TopBit] | pmc[2][TopBit] | pmc[3][TopBit])))
          pend_vec[P_PERF] = 1'b1;
      end
      KIND_CHECK_ALL: begin
        if (pend_vec[P_ISI])
          r = take(r, P_ISI, VEC_ISI, it.next_pc, ISI_REASON, it.msr_in);
        else if (pend_vec[P_PROG])
          r = take(r, P_PROG, VEC_PROG, it.cur_pc, it.srr1_prior, it.msr_in);
        else if (pend_vec[P_SC])
          r = take(r, P_SC, VEC_SC, it.next_pc, '0, it.msr_in);
        else if (pend_vec[P_FPU])
          r = take(r, P_FPU, VEC_FPU, it.cur_pc, '0, it.msr_in);
        else if (pend_vec[P_MCHK]) begin
          // memcheck swallows itself and any data storage fault, dispatching nothing
          pend_vec[P_MCHK] = 1'b0;
          pend_vec[P_DSI] = 1'b0;
        end else if (pend_vec[P_DSI])
          r = take(r, P_DSI, VEC_DSI, it.cur_pc, '0, it.msr_in);
        else if (pend_vec[P_ALIGN])
          r = take(r, P_ALIGN, VEC_ALIGN, it.cur_pc, '0, it.msr_in);
        else
          r = external_check(r, it.next_pc, it.msr_in);
      end
      default: r = external_check(r, it.next_pc, it.msr_in);
    endcase
    r.pending_out = pend_vec;
    r.counter1 = pmc[0];
    r.counter2 = pmc[1];
    r.counter3 = pmc[2];
    r.counter4 = pmc[3];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 results_seen, name, want_v, got_v);
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
    dispatched = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pend_vec = '0;
      pmc = '0;
      sel1 = '0;
      sel2 = '0;
      sel3 = '0;
      sel4 = '0;
      int_en1 = 1'b0;
      int_enn = 1'b0;
      outcome_queue.delete();
    end else begin
      // Retire first, so a result can never match the item accepted on the same edge.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (outcome_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: %h", results_seen, m_tdata);
        end else begin
          want = outcome_queue.pop_front();
          check_field("taken", want.taken, got.taken);
          check_field("vector", want.vector, got.vector);
          check_field("srr0_out", want.srr0_out, got.srr0_out);
          check_field("srr1_out", want.srr1_out, got.srr1_out);
          check_field("msr_out", want.msr_out, got.msr_out);
          check_field("pending_out", want.pending_out, got.pending_out);
          check_field("unknown_external", want.unknown_external, got.unknown_external);
          check_field("counter1", want.counter1, got.counter1);
          check_field("counter2", want.counter2, got.counter2);
          check_field("counter3", want.counter3, got.counter3);
          check_field("counter4", want.counter4, got.counter4);
          if (want.taken) dispatched++;
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        seen.kind = kind_t'(s_tuser);
        seen.raise_mask = s_tdata[9:0];
        seen.cycle_count = s_tdata[41:10];
        seen.load_store_count = s_tdata[73:42];
        seen.fp_count = s_tdata[105:74];
        seen.cur_pc = s_tdata[137:106];
        seen.next_pc = s_tdata[169:138];
        seen.msr_in = s_tdata[201:170];
        seen.srr1_prior = s_tdata[233:202];
        outcome_queue.push_back(next_outcome(seen));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PMC1_SELECT:     sel1 = cfg_data[6:0];
          CFG_PMC2_SELECT:     sel2 = cfg_data[5:0];
          CFG_PMC3_SELECT:     sel3 = cfg_data[4:0];
          CFG_PMC4_SELECT:     sel4 = cfg_data[4:0];
          CFG_PMC1_INT_ENABLE: int_en1 = cfg_data[0];
          CFG_PMCN_INT_ENABLE: int_enn = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = outcome_queue.size();
  end

endmodule

`default_nettype wire

@@ test/tb_exception_dispatch_perf_monitor.sv @@
// Testbench top: clock, reset, stimulus and verdict for the exception dispatch and performance monitor.
`timescale 1ns / 1ps
`default_nettype none

module tb_exception_dispatch_perf_monitor;
  import edpm_pkg::*;

  // Far beyond the slowest legal run: ~805 items, 15% gaps on both sides,
  // one long receiver hold-off and a handful of drains.
  localparam int unsigned RunLimitNs = 3_000_000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseItems = 130;
  localparam logic [31:0] MsrEe  = 32'd1 << MSR_EE;
  localparam logic [31:0] MsrIle = 32'd1 << MSR_ILE;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [239:0]        s_tdata;    // raise_mask, cycle_count, load_store_count, fp_count,
                                   // cur_pc, next_pc, msr_in, srr1_prior, zero pad
  logic [1:0]          s_tuser;    // kind
  logic                m_tvalid;
  logic                m_tready;
  logic [247:0]        m_tdata;    // taken, vector, srr0_out, srr1_out, msr_out, pending_out,
                                   // unknown_external, counter1..counter4
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int dispatched;

  // Knobs shared between the sender and the receiver process.
  bit tx_idle_en;
  bit rx_idle_en;
  int hold_requests;
  int holds_done;
  int sent_by_kind[4];
  int settings_applied;

  exception_dispatch_perf_monitor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  edpm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen),
    .dispatched  (dispatched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RunLimitNs);
    $display("exception_dispatch_perf_monitor regression: fail");
    $finish;
  end

  // Receiver: drop tready at random, and honor a hold-off request by keeping
  // tready low while the sender keeps pushing.
  initial begin
    m_tready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      m_tready = rx_idle_en ? ($urandom_range(99) >= 15) : 1'b1;
    end
  end

  // Build a random item. Raise masks lean toward one or a few bits so that
  // checks walk the whole priority chain instead of always finding isi.
  function automatic item_t random_item();
    item_t it;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) it.kind = KIND_RAISE;
    else if (roll < 50) it.kind = KIND_COUNT;
    else if (roll < 80) it.kind = KIND_CHECK_ALL;
    else it.kind = KIND_CHECK_EXT;
    roll = $urandom_range(99);
    if (roll < 50) it.raise_mask = 10'd1 << $urandom_range(PendW - 1);
    else if (roll < 80) it.raise_mask = 10'($urandom & $urandom & $urandom);
    else if (roll < 95) it.raise_mask = 10'($urandom);
    else it.raise_mask = '0;
    // Small counts mostly, so counters do not sit with bit 31 set forever.
    it.cycle_count = $urandom_range(1) ? $urandom_range(255) : $urandom;
    it.load_store_count = $urandom_range(1) ? $urandom_range(255) : $urandom;
    it.fp_count = $urandom_range(1) ? $urandom_range(255) : $urandom;
    it.cur_pc = $urandom;
    it.next_pc = $urandom;
    it.msr_in = $urandom;
    it.srr1_prior = $urandom;
    return it;
  endfunction

  // Offer one item from a falling edge; return on the falling edge after it is taken.
  // tvalid is left high so back-to-back items keep it asserted.
  task automatic drive_item(input item_t it);
    while (tx_idle_en && $urandom_range(99) < 15) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = it.kind;
    s_tdata = {6'd0, it.srr1_prior, it.msr_in, it.next_pc, it.cur_pc,
               it.fp_count, it.load_store_count, it.cycle_count, it.raise_mask};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_by_kind[it.kind]++;
    @(negedge clk);
  endtask

  task automatic send(input kind_t k, input logic [9:0] mask, input logic [31:0] msr);
    item_t it;
    it = random_item();
    it.kind = k;
    it.raise_mask = mask;
    it.msr_in = msr;
    drive_item(it);
  endtask

  task automatic send_counts(input logic [31:0] cyc, input logic [31:0] ls,
                             input logic [31:0] fp);
    item_t it;
    it = random_item();
    it.kind = KIND_COUNT;
    it.cycle_count = cyc;
    it.load_store_count = ls;
    it.fp_count = fp;
    drive_item(it);
  endtask

  // Hold the input quiet until every expected result is back, then let the block settle.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Enable bits go out with junk in the upper data bits; only bit 0 counts.
  task automatic program_monitor(input logic [6:0] s1, input logic [5:0] s2,
                                 input logic [4:0] s3, input logic [4:0] s4,
                                 input logic e1, input logic en);
    write_reg(CFG_PMC1_SELECT, s1);
    write_reg(CFG_PMC2_SELECT, {1'b0, s2});
    write_reg(CFG_PMC3_SELECT, {2'b0, s3});
    write_reg(CFG_PMC4_SELECT, {2'b0, s4});
    write_reg(CFG_PMC1_INT_ENABLE, {6'($urandom), e1});
    write_reg(CFG_PMCN_INT_ENABLE, {6'($urandom), en});
    settings_applied++;
  endtask

  // One third each: the first code, the second code, or anything at all.
  function automatic logic [6:0] pick_select(input logic [6:0] a, input logic [6:0] b);
    int unsigned roll;
    roll = $urandom_range(2);
    return (roll == 0) ? a : (roll == 1) ? b : 7'($urandom);
  endfunction

  initial begin
    item_t it;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_RAISE;
    cfg_we = 1'b0;
    cfg_index = CFG_PMC1_SELECT;
    cfg_data = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_requests = 0;
    settings_applied = 0;
    foreach (sent_by_kind[k]) sent_by_kind[k] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset settings: every select is zero, so counters must not move.
    send_counts('1, '1, '1);
    send(KIND_CHECK_ALL, '0, '1);            // nothing pending
    send(KIND_CHECK_EXT, '0, MsrEe);         // nothing pending, EE on
    send(KIND_RAISE, 10'h3FF, '0);           // every source pending
    send(KIND_CHECK_EXT, '0, ~MsrEe);        // external sources masked by EE
    send(KIND_CHECK_EXT, '0, MsrEe | MsrIle); // ext taken, LE from ILE
    send(KIND_CHECK_ALL, '0, MsrIle);        // isi, reason bit in SRR1
    send(KIND_CHECK_ALL, '0, '1);            // program, prior reason bits merged
    send(KIND_CHECK_ALL, '0, '0);            // syscall
    send(KIND_CHECK_ALL, '0, MsrIle | 32'd1); // fpu
    send(KIND_CHECK_ALL, '0, '1);            // memcheck: clears itself and dsi, no dispatch
    send(KIND_CHECK_ALL, '0, '1);            // align
    send(KIND_CHECK_ALL, '0, ~MsrEe);        // only external left, EE off: nothing
    send(KIND_CHECK_ALL, '0, MsrEe);         // perf through the full check
    send(KIND_CHECK_ALL, '0, MsrEe);         // dec
    send(KIND_RAISE, 10'd1 << P_DSI, '0);
    send(KIND_CHECK_ALL, '0, '0);            // dsi on its own
    send(KIND_RAISE, 10'h07F, '0);           // non-external sources only
    send(KIND_CHECK_EXT, '0, MsrEe);         // unknown external
    send(KIND_RAISE, '0, '0);
    send(KIND_CHECK_EXT, '0, '0);
    wait_drained();

    // Directed counters: climb to just under bit 31, cross it, then wrap.
    program_monitor(SEL_CYCLES, SEL_LOAD_STORE[5:0], SEL_FPU[4:0], SEL_CYCLES[4:0], 1'b1, 1'b1);
    send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_counts(32'd1, 32'd0, 32'd0);         // counter one reaches bit 31: perf pending
    send_counts('1, '1, '1);
    send(KIND_CHECK_EXT, '0, MsrEe);
    wait_drained();

    // Random phases, one setting each.
    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      case (phase)
        0: program_monitor(SEL_CYCLES, SEL_CYCLES[5:0], SEL_CYCLES[4:0], SEL_CYCLES[4:0],
                           1'b1, 1'b1);
        1: begin
          // Long stretch with neither side idling.
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
          program_monitor(SEL_CYCLES, SEL_LOAD_STORE[5:0], SEL_FPU[4:0], SEL_CYCLES[4:0],
                          1'b0, 1'b1);
        end
        2: program_monitor(7'h7F, 6'h3F, 5'h1F, 5'h1F, 1'b1, 1'b1);
        3: begin
          // Indexes past the last register must be ignored.
          write_reg(3'd6, 7'($urandom));
          write_reg(3'd7, 7'($urandom));
          program_monitor('0, '0, '0, '0, 1'b0, 1'b0);
        end
        4: program_monitor(pick_select(7'd0, SEL_CYCLES),
                           6'(pick_select(SEL_CYCLES, SEL_LOAD_STORE)),
                           5'(pick_select(SEL_CYCLES, SEL_FPU)),
                           5'(pick_select(7'd0, SEL_CYCLES)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
        default: program_monitor(SEL_CYCLES, SEL_LOAD_STORE[5:0], SEL_FPU[4:0],
                                 SEL_CYCLES[4:0], 1'b1, 1'b0);
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // Back up the block: the receiver stalls while the sender keeps offering.
        if (phase == 2 && n == 40) hold_requests++;
        // Let the pipe empty completely mid-phase.
        if (phase == 3 && n == 60) wait_drained();
        it = random_item();
        drive_item(it);
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("covered %0d raise, %0d counter, %0d full-check, %0d external-check items",
             sent_by_kind[KIND_RAISE], sent_by_kind[KIND_COUNT],
             sent_by_kind[KIND_CHECK_ALL], sent_by_kind[KIND_CHECK_EXT]);
    $display("%0d results checked, %0d dispatches, %0d settings, %0d mismatches",
             results_seen, dispatched, settings_applied, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("exception_dispatch_perf_monitor regression: pass");
    else
      $display("exception_dispatch_perf_monitor regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ exception_dispatch_perf_monitor.f @@
+incdir+hdl
hdl/edpm_pkg.sv
hdl/edpm_core.sv
hdl/exception_dispatch_perf_monitor.sv
test/edpm_checker.sv
test/tb_exception_dispatch_perf_monitor.sv
